// ===== hdl/chained_hash_table_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Chained hash table engine assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CHTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/chte_pkg.sv =====
// ----------------------------------------------------------------------------
// Chained hash table engine package
// Transaction types, request and status codes, hash constants.
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int CFG_W = 11;
    localparam int ENTRY_W = 11;

    localparam logic [31:0] MIX_MUL = 32'h045d_9f3b;
    localparam int MIX_SHIFT = 16;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key;
        logic [31:0] value;
    } t_chte_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        found_value;
        logic [ENTRY_W-1:0] entry_total;
    } t_chte_res;

    localparam int REQ_W = $bits(t_chte_req);

    // back end status seen by the front end
    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

// ===== hdl/chte_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/chte_fifo.sv =====
// ----------------------------------------------------------------------------
// Two-entry queue
// Decouples the hashing front end from the table back end.
// ----------------------------------------------------------------------------
module chte_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_slot[r_wptr] <= i_data;
                r_wptr         <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/chte_front.sv =====
// ----------------------------------------------------------------------------
// Hash front end
// Accepts a request, mixes the key and reduces it modulo the bucket count (zero taken as one, clamped to BUCKETS).
// ----------------------------------------------------------------------------
module chte_front #(
    parameter int BUCKETS = 1024,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int DW = $clog2(BUCKETS + 1),
    localparam int CW = (DW > chte_pkg::CFG_W) ? DW : chte_pkg::CFG_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [CW-1:0]          i_bucket_count,
    input  chte_pkg::t_back_stat   i_bstat,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  chte_pkg::t_chte_req    i_req,
    output logic                   o_valid,
    input  logic                   i_ready,
    output chte_pkg::t_chte_req    o_req,
    output logic [BW-1:0]          o_bucket
);

    import chte_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_MIX1, F_MIX2, F_FOLD, F_DIV, F_PUSH} t_fstate;

    t_fstate     r_state;
    t_chte_req   r_req;
    logic [31:0] r_x;
    logic [DW-1:0] r_rem;
    logic [4:0]  r_cnt;

    logic [31:0]   w_fold;
    logic [31:0]   w_prod;
    logic [DW-1:0] w_mod;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;

    always_comb begin
        if (i_bucket_count == '0) begin
            w_mod = DW'(1);
        end else if (i_bucket_count > CW'(BUCKETS)) begin
            w_mod = DW'(BUCKETS);
        end else begin
            w_mod = i_bucket_count[DW-1:0];
        end
    end

    assign w_fold  = (r_x >> MIX_SHIFT) ^ r_x;
    assign w_prod  = w_fold * MIX_MUL;
    // restoring division, one quotient bit a cycle
    assign w_trial = {r_rem, r_x[31]};
    assign w_diff  = w_trial - {1'b0, w_mod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req   <= i_req;
                        r_x     <= i_req.key;
                        r_state <= F_MIX1;
                    end
                end
                F_MIX1: begin
                    r_x     <= w_prod;
                    r_state <= F_MIX2;
                end
                F_MIX2: begin
                    r_x     <= w_prod;
                    r_state <= F_FOLD;
                end
                F_FOLD: begin
                    r_x     <= w_fold;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= F_DIV;
                end
                F_DIV: begin
                    r_rem <= (w_trial >= {1'b0, w_mod}) ? w_diff[DW-1:0] : w_trial[DW-1:0];
                    r_x   <= {r_x[30:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (i_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_ready  = (r_state == F_IDLE) && !i_bstat.clearing;
    assign o_valid  = (r_state == F_PUSH);
    assign o_req    = r_req;
    assign o_bucket = r_rem[BW-1:0];

endmodule

// ===== hdl/chte_back.sv =====
// ----------------------------------------------------------------------------
// Table back end
// Bucket heads, node store and free list; inserts, walks and unlinks chains.
// ----------------------------------------------------------------------------
module chte_back #(
    parameter int BUCKETS = 1024,
    parameter int NODES = 1024,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    output chte_pkg::t_back_stat o_bstat,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  chte_pkg::t_chte_req  i_req,
    input  logic [BW-1:0]        i_bucket,
    output logic                 o_valid,
    input  logic                 i_ready,
    output chte_pkg::t_chte_res  o_res
);

    import chte_pkg::*;

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int NW = $clog2(NODES + 1);
    localparam logic [NW-1:0] NIL = NW'(NODES);

    typedef enum logic [2:0] {B_CLR, B_IDLE, B_INS, B_HEAD, B_NODE, B_DONE} t_bstate;

    t_bstate     r_state;
    logic [BW-1:0] r_clr;
    t_chte_req   r_req;
    logic [BW-1:0] r_bucket;
    logic [NW-1:0] r_cur;
    logic [NW-1:0] r_prev;
    logic [NW-1:0] r_fresh;
    logic [NW-1:0] r_scnt;
    logic [NW-1:0] r_entries;
    logic [1:0]  r_status;
    logic [31:0] r_found;
    logic        r_ovalid;
    t_chte_res   r_res;

    logic [NW-1:0] head_rd;
    logic [31:0]   key_rd;
    logic [31:0]   val_rd;
    logic [NW-1:0] next_rd;
    logic [IW-1:0] stack_rd;

    logic          head_we;
    logic [BW-1:0] head_waddr;
    logic [NW-1:0] head_wdata;
    logic [BW-1:0] head_raddr;
    logic          next_we;
    logic [IW-1:0] next_waddr;
    logic [NW-1:0] next_wdata;
    logic          kv_we;
    logic [IW-1:0] node_raddr;
    logic          stack_we;
    logic [IW-1:0] stack_raddr;

    logic          w_full;
    logic [NW-1:0] w_node;
    logic          w_match;
    logic          w_unlink;
    logic          w_load;

    assign w_full   = (r_fresh == NIL) && (r_scnt == '0);
    assign w_node   = (r_fresh != NIL) ? r_fresh : NW'(stack_rd);
    assign w_match  = (key_rd == r_req.key);
    assign w_unlink = (r_state == B_NODE) && w_match && (r_req.req_type == REQ_REMOVE);
    // result register takes a new transaction when empty or being drained
    assign w_load   = (r_state == B_DONE) && (!r_ovalid || i_ready);

    assign head_raddr  = (r_state == B_IDLE) ? i_bucket : r_bucket;
    assign stack_raddr = IW'(r_scnt - NW'(1));

    always_comb begin
        head_we    = 1'b0;
        head_waddr = r_bucket;
        head_wdata = w_node;
        next_we    = 1'b0;
        next_waddr = w_node[IW-1:0];
        next_wdata = head_rd;
        kv_we      = 1'b0;
        stack_we   = 1'b0;
        case (r_state)
            B_HEAD:  node_raddr = head_rd[IW-1:0];
            B_NODE:  node_raddr = next_rd[IW-1:0];
            default: node_raddr = r_cur[IW-1:0];
        endcase
        case (r_state)
            B_CLR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                head_wdata = NIL;
            end
            B_INS: begin
                if (!w_full) begin
                    head_we = 1'b1;
                    next_we = 1'b1;
                    kv_we   = 1'b1;
                end
            end
            B_NODE: begin
                if (w_unlink) begin
                    stack_we = 1'b1;
                    if (r_prev == NIL) begin
                        head_we    = 1'b1;
                        head_wdata = next_rd;
                    end else begin
                        next_we    = 1'b1;
                        next_waddr = r_prev[IW-1:0];
                        next_wdata = next_rd;
                    end
                end
            end
            default: ;
        endcase
    end

    chte_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rd)
    );
    chte_ram #(.WIDTH(32), .DEPTH(NODES)) u_key (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(w_node[IW-1:0]), .i_wdata(r_req.key),
        .i_raddr(node_raddr), .o_rdata(key_rd)
    );
    chte_ram #(.WIDTH(32), .DEPTH(NODES)) u_val (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(w_node[IW-1:0]), .i_wdata(r_req.value),
        .i_raddr(node_raddr), .o_rdata(val_rd)
    );
    chte_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_waddr), .i_wdata(next_wdata),
        .i_raddr(node_raddr), .o_rdata(next_rd)
    );
    chte_ram #(.WIDTH(IW), .DEPTH(NODES)) u_stack (
        .i_clk(i_clk), .i_we(stack_we), .i_waddr(r_scnt[IW-1:0]), .i_wdata(r_cur[IW-1:0]),
        .i_raddr(stack_raddr), .o_rdata(stack_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_CLR;
            r_clr     <= '0;
            r_fresh   <= '0;
            r_scnt    <= '0;
            r_entries <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_CLR: begin
                    r_clr <= r_clr + BW'(1);
                    if (r_clr == BW'(BUCKETS - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (i_valid) begin
                        r_req    <= i_req;
                        r_bucket <= i_bucket;
                        r_status <= ST_NOTFOUND;
                        r_found  <= '0;
                        if (i_req.req_type == REQ_INSERT) begin
                            r_state <= B_INS;
                        end else if (i_req.req_type inside {REQ_LOOKUP, REQ_REMOVE}) begin
                            r_state <= B_HEAD;
                        end else begin
                            r_state <= B_DONE;
                        end
                    end
                end
                B_INS: begin
                    if (w_full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status <= ST_OK;
                        if (r_fresh != NIL) begin
                            r_fresh <= r_fresh + NW'(1);
                        end else begin
                            r_scnt <= r_scnt - NW'(1);
                        end
                        r_entries <= r_entries + NW'(1);
                    end
                    r_state <= B_DONE;
                end
                B_HEAD: begin
                    r_cur  <= head_rd;
                    r_prev <= NIL;
                    r_state <= (head_rd == NIL) ? B_DONE : B_NODE;
                end
                B_NODE: begin
                    if (w_match) begin
                        r_status <= ST_OK;
                        r_found  <= val_rd;
                        if (w_unlink) begin
                            r_scnt    <= r_scnt + NW'(1);
                            r_entries <= r_entries - NW'(1);
                        end
                        r_state <= B_DONE;
                    end else if (next_rd == NIL) begin
                        r_state <= B_DONE;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= next_rd;
                    end
                end
                B_DONE: begin
                    if (w_load) begin
                        r_res.status      <= r_status;
                        r_res.found_value <= r_found;
                        r_res.entry_total <= ENTRY_W'(r_entries);
                        r_state           <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_bstat.clearing = (r_state == B_CLR);
    assign o_ready = (r_state == B_IDLE);
    assign o_valid = r_ovalid;
    assign o_res   = r_res;

endmodule

// ===== hdl/chained_hash_table_engine.sv =====
// ----------------------------------------------------------------------------
// Chained hash table engine
// Separate-chaining key/value table with a hashing front end and a
// memory-backed back end joined by a two-entry queue.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  request   in         i_valid / o_ready       i_req  (req_type, key, value)
//  result    out        o_valid / i_ready       o_res  (status, found_value, entry_total)
//  config    in         i_cfg_we                i_cfg_data (bucket_count)
//
//  Front end: two registered multiplies and the fold, then the one-bit-a-cycle
//  modulo (32 steps); no new request is taken until the result is queued.
//  Back end: one node memory read per chain step; the next transaction is
//  taken only once the current result is loaded into the result register.
//  After reset the bucket heads are swept empty; no request is taken until
//  the sweep ends. Configuration is accepted always.
//  The queue lets hashing of the next transaction run while the back end
//  or a stalled result holds.
// ----------------------------------------------------------------------------
module chained_hash_table_engine #(
    parameter int BUCKETS = 1024,
    parameter int NODES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  chte_pkg::t_chte_req  i_req,
    output logic                 o_valid,
    input  logic                 i_ready,
    output chte_pkg::t_chte_res  o_res,
    input  logic                 i_cfg_we,
    input  logic [chte_pkg::CFG_W-1:0] i_cfg_data
);

    import chte_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int DW = $clog2(BUCKETS + 1);
    localparam int CW = (DW > CFG_W) ? DW : CFG_W;
    localparam int QW = REQ_W + BW;

    // bucket count register, wide enough to hold BUCKETS out of reset
    logic [CW-1:0] r_bucket_count;

    t_back_stat  bstat;
    logic        f_valid;
    logic        f_ready;
    t_chte_req   f_req;
    logic [BW-1:0] f_bucket;
    logic        q_valid;
    logic        q_ready;
    logic [QW-1:0] q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= CW'(BUCKETS);
        end else if (i_cfg_we) begin
            r_bucket_count <= CW'(i_cfg_data);
        end
    end

    // hashing and bucket select
    chte_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_count (r_bucket_count),
        .i_bstat        (bstat),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req          (i_req),
        .o_valid        (f_valid),
        .i_ready        (f_ready),
        .o_req          (f_req),
        .o_bucket       (f_bucket)
    );

    // classified transactions wait here for the back end
    chte_fifo #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_req, f_bucket}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    // table storage and chain operations; owns the result register
    chte_back #(.BUCKETS(BUCKETS), .NODES(NODES)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .o_bstat  (bstat),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_req    (q_data[QW-1:BW]),
        .i_bucket (q_data[BW-1:0]),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_res    (o_res)
    );

endmodule

// ===== hdl/chte_checker.sv =====
// ----------------------------------------------------------------------------
// Chained hash table engine checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "chained_hash_table_engine_macros.svh"

module chte_checker #(
    parameter int NODES = 1024
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input chte_pkg::t_chte_res o_res
);

    import chte_pkg::*;

    logic w_hold;
    logic w_legal;
    logic w_failed;
    logic w_zero;
    logic w_bounded;

    assign w_hold    = o_valid && !i_ready;
    assign w_legal   = (o_res.status == ST_OK) || (o_res.status == ST_NOTFOUND) ||
                       (o_res.status == ST_FULL);
    assign w_failed  = o_valid && (o_res.status != ST_OK);
    assign w_zero    = (o_res.found_value == 32'd0);
    assign w_bounded = (32'(o_res.entry_total) <= 32'(NODES)) || (NODES > 2047);

    `CHTE_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, w_hold, o_valid && $stable(o_res), "result moved")
    `CHTE_ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_valid, w_legal, "illegal status")
    `CHTE_ASSERT_SAME(a_value_zero, i_clk, i_rst_n, w_failed, w_zero, "value on failed request")
    `CHTE_ASSERT_SAME(a_entry_bound, i_clk, i_rst_n, o_valid, w_bounded, "entry total above pool")

endmodule

bind chained_hash_table_engine chte_checker #(.NODES(NODES)) u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_res   (o_res)
);
